// File: rtl/hhgs_pkg.sv
// Package for the hysteresis gear stepper: codes, constants and shared types.
package hhgs_pkg;

    localparam int DEFAULT_MAX_GEAR = 4;

    localparam int GEAR_W   = 3;
    localparam int COUNT_W  = 8;
    localparam int THRESH_W = 20;
    localparam int SAMPLE_W = 24;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam logic [THRESH_W-1:0] OFF_THRESHOLD = 20'd999999;
    localparam logic [COUNT_W-1:0]  FALLBACK_HOLD = 8'd4;
    localparam logic [COUNT_W-1:0]  COUNT_MAX     = 8'd255;

    // Boost mode codes.
    localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AGGR   = 2'd2;

    // Input item kinds.
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BOOST_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_ON_HOLD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_OFF_HOLD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AGGR_THRESHOLD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AGGR_ON_HOLD     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AGGR_OFF_HOLD    = 3'd6;

    typedef struct packed {
        logic [GEAR_W-1:0]  gear;
        logic [COUNT_W-1:0] over;
        logic [COUNT_W-1:0] under;
    } hhgs_state_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [THRESH_W-1:0] normal_threshold;
        logic [COUNT_W-1:0]  normal_on_hold;
        logic [COUNT_W-1:0]  normal_off_hold;
        logic [THRESH_W-1:0] aggr_threshold;
        logic [COUNT_W-1:0]  aggr_on_hold;
        logic [COUNT_W-1:0]  aggr_off_hold;
    } hhgs_cfg_t;

endpackage

// File: rtl/hhgs_step.sv
// One item's update of gear and hold counters, with the profile selection.
module hhgs_step #(
    parameter int MAX_GEAR = hhgs_pkg::DEFAULT_MAX_GEAR
) (
    input  hhgs_pkg::hhgs_cfg_t                 cfg,
    input  hhgs_pkg::hhgs_state_t               state,
    input  logic                                kind,
    input  logic [hhgs_pkg::SAMPLE_W-1:0]       rate_sample,
    output hhgs_pkg::hhgs_state_t               state_next,
    output logic [hhgs_pkg::THRESH_W-1:0]       threshold
);
    import hhgs_pkg::*;

    localparam logic [GEAR_W-1:0] MAX_GEAR_L = GEAR_W'(MAX_GEAR);

    logic [COUNT_W-1:0]  on_hold;
    logic [COUNT_W-1:0]  down_hold;
    logic                is_high;
    logic                is_low;
    logic [SAMPLE_W+2:0] sample_x5;
    logic [COUNT_W-1:0]  over_inc;
    logic [COUNT_W-1:0]  under_inc;

    always_comb
    begin
        case (cfg.mode)
            MODE_AGGR:
            begin
                threshold = cfg.aggr_threshold;
                on_hold   = cfg.aggr_on_hold;
                down_hold = cfg.aggr_off_hold;
            end
            MODE_NORMAL:
            begin
                threshold = cfg.normal_threshold;
                on_hold   = cfg.normal_on_hold;
                down_hold = cfg.normal_off_hold;
            end
            default:
            begin
                threshold = OFF_THRESHOLD;
                on_hold   = FALLBACK_HOLD;
                down_hold = FALLBACK_HOLD;
            end
        endcase
    end

    // High level is threshold*16 in Q.4; the low level at 80% is tested as
    // sample*5 < threshold*64, which needs no fraction.
    assign sample_x5 = {1'b0, rate_sample, 2'b00} + {3'b000, rate_sample};
    assign is_high   = rate_sample >= {threshold, 4'b0000};
    assign is_low    = sample_x5 < {1'b0, threshold, 6'b000000};
    assign over_inc  = (state.over == COUNT_MAX) ? COUNT_MAX : state.over + 8'd1;
    assign under_inc = (state.under == COUNT_MAX) ? COUNT_MAX : state.under + 8'd1;

    always_comb
    begin
        state_next = state;
        if (kind == KIND_RELEASE || cfg.mode == MODE_OFF)
        begin
            state_next = '0;
        end
        else if (is_high)
        begin
            state_next.under = '0;
            state_next.over  = over_inc;
            if (over_inc >= on_hold && state.gear < MAX_GEAR_L)
            begin
                state_next.gear = state.gear + 3'd1;
                state_next.over = '0;
            end
        end
        else if (is_low)
        begin
            state_next.over  = '0;
            state_next.under = under_inc;
            if (under_inc >= down_hold && state.gear != '0)
            begin
                state_next.gear  = state.gear - 3'd1;
                state_next.under = '0;
            end
        end
        else
        begin
            state_next.over  = '0;
            state_next.under = '0;
        end
    end

endmodule

// File: rtl/hold_hysteresis_gear_stepper.sv
// Top level of the hysteresis gear stepper: stream ports, registers, config.
//
// The block steps a boost gear between 0 and MAX_GEAR from a stream of rate
// samples. Each input item on the s_ channel is either a rate sample tick
// (s_tuser = 0, sample in s_tdata as unsigned Q.4 kbps) or a release
// (s_tuser = 1) that clears the gear and both hold counters. Every item
// produces exactly one result item on the m_ channel carrying the gear after
// that item and the threshold of the profile in use (999999 when boost is off).
// An item is taken into an input register, the update runs in
// combinational logic, and the result lands in an output register, so
// m_tvalid rises once the item has moved from the input register into the
// output register. One item per cycle is sustained while the receiver takes
// results; the only loop is the gear/counter state register. The output
// register parts the two sides: while the receiver stalls, one more item
// is held in the input register and s_tready drops only when both registers
// are full. Configuration writes via cfg_we/cfg_index/cfg_data take effect
// at the next edge and are expected only while no item is in flight. Reset
// clears the gear, both counters and both pipeline valids and loads the
// register defaults (boost off).
module hold_hysteresis_gear_stepper #(
    parameter int MAX_GEAR = hhgs_pkg::DEFAULT_MAX_GEAR
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [hhgs_pkg::IN_TDATA_W-1:0]      s_tdata,   // [23:0] rate_sample
    input  logic                                 s_tuser,   // [0] kind
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [hhgs_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [2:0] gear_level,
                                                            // [22:3] active_threshold
    input  logic                                 cfg_we,
    input  logic [hhgs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hhgs_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import hhgs_pkg::*;

    hhgs_cfg_t             cfg_reg;
    hhgs_state_t           state_reg;
    hhgs_state_t           state_next;
    logic                  in_valid_reg;
    logic                  in_kind_reg;
    logic [SAMPLE_W-1:0]   in_sample_reg;
    logic                  out_valid_reg;
    logic [GEAR_W-1:0]     out_gear_reg;
    logic [THRESH_W-1:0]   out_thresh_reg;
    logic [THRESH_W-1:0]   thresh_next;
    logic                  advance;

    // The input register moves forward whenever the output register is free
    // or is being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_thresh_reg, out_gear_reg};

    hhgs_step #(
        .MAX_GEAR (MAX_GEAR)
    ) u_step (
        .cfg         (cfg_reg),
        .state       (state_reg),
        .kind        (in_kind_reg),
        .rate_sample (in_sample_reg),
        .state_next  (state_next),
        .threshold   (thresh_next)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_kind_reg   <= s_tuser;
            in_sample_reg <= s_tdata[SAMPLE_W-1:0];
        end
    end

    // Gear and counter state, updated once per item that moves forward.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_gear_reg   <= state_next.gear;
            out_thresh_reg <= thresh_next;
        end
    end

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode             <= MODE_OFF;
            cfg_reg.normal_threshold <= 20'd500;
            cfg_reg.normal_on_hold   <= 8'd4;
            cfg_reg.normal_off_hold  <= 8'd4;
            cfg_reg.aggr_threshold   <= 20'd250;
            cfg_reg.aggr_on_hold     <= 8'd2;
            cfg_reg.aggr_off_hold    <= 8'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BOOST_MODE:       cfg_reg.mode             <= cfg_data[MODE_W-1:0];
                REG_NORMAL_THRESHOLD: cfg_reg.normal_threshold <= cfg_data[THRESH_W-1:0];
                REG_NORMAL_ON_HOLD:   cfg_reg.normal_on_hold   <= cfg_data[COUNT_W-1:0];
                REG_NORMAL_OFF_HOLD:  cfg_reg.normal_off_hold  <= cfg_data[COUNT_W-1:0];
                REG_AGGR_THRESHOLD:   cfg_reg.aggr_threshold   <= cfg_data[THRESH_W-1:0];
                REG_AGGR_ON_HOLD:     cfg_reg.aggr_on_hold     <= cfg_data[COUNT_W-1:0];
                REG_AGGR_OFF_HOLD:    cfg_reg.aggr_off_hold    <= cfg_data[COUNT_W-1:0];
                default:              ;
            endcase
        end
    end

    // The gear never leaves its range.
    a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.gear <= GEAR_W'(MAX_GEAR))
        else $error("gear above maximum");

    // A sample clears one counter whenever it moves the other.
    a_counts_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg.over != '0 && state_reg.under != '0))
        else $error("both hold counters nonzero");

    // A release or a tick with boost off leaves everything cleared.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_kind_reg == KIND_RELEASE || cfg_reg.mode == MODE_OFF))
        |=> (state_reg == '0 && out_gear_reg == '0))
        else $error("state not cleared");

    // State changes only when an item moves through.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without an item");

    // The reported gear is the stored gear.
    a_out_matches: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_gear_reg == state_reg.gear))
        else $error("result gear differs from state");

endmodule
